// ----- hw/rtl/multi_plane_column_bit_compress_core_defines.svh -----
// Assertion macros shared by the column compress RTL.
`ifndef MULTI_PLANE_COLUMN_BIT_COMPRESS_CORE_DEFINES_SVH
`define MULTI_PLANE_COLUMN_BIT_COMPRESS_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on every rising clk_i edge, skipped while rst_ni is low.
`define MPCBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check on every rising clk_i edge, reset included.
`define MPCBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MPCBC_ASSERT(lbl, prop, msg)
`define MPCBC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/mpcbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mpcbc_pkg;

  localparam int FieldW     = 16;
  localparam int PlaneSlots = 5;
  localparam int ColorW     = 5;
  localparam int RankW      = $clog2(FieldW);
  localparam int CountW     = $clog2(FieldW) + 1;
  localparam int InDataW    = FieldW * (PlaneSlots + 1);
  localparam int OutRawW    = FieldW * (PlaneSlots + 1) + ColorW;
  localparam int OutDataW   = ((OutRawW + 7) / 8) * 8;
  localparam int OutPadW    = OutDataW - OutRawW;

  typedef logic [FieldW-1:0] field_t;

  // Compaction info: masked occupancy, packed flag, packed occupancy, per-cell destination index.
  typedef struct packed {
    logic                         packed_col;
    field_t                       occ;
    field_t                       packed_occ;
    logic [FieldW-1:0][RankW-1:0] rank;
  } rank_info_t;

endpackage

`default_nettype wire

// ----- hw/rtl/multi_plane_column_bit_compress_core.sv -----
// Column compress core: one column per cycle, sustained while the output is not stalled.
// Each column passes the input register (s1_*_q) and then the result register (out_*_q).
// Throughput: 1 column per cycle unless stalled; the compress logic sits between the registers.
// Reset: rst_ni (async, active low) clears valid flags and the changed-color accumulator.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_plane_column_bit_compress_core_defines.svh"

module multi_plane_column_bit_compress_core #(
  parameter int COLUMN_HEIGHT = 16,
  parameter int NUM_COLORS    = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // occupancy, plane_0, plane_1, plane_2, plane_3, plane_4 (16 bits each, from bit 0)
  input  logic [mpcbc_pkg::InDataW-1:0]   s_axis_tdata_i,
  // last_column
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // packed_occupancy, packed_0..packed_4 (16 bits each), changed_colors (5), zero pad
  output logic [mpcbc_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // pass_done
  output logic                            m_axis_tlast_o
);
  import mpcbc_pkg::*;

  localparam logic [ColorW-1:0] UsedMask = ColorW'((32'(1) << NUM_COLORS) - 32'(1));

  logic                  s1_valid_q;
  logic [InDataW-1:0]    s1_data_q;
  logic                  s1_last_q;
  logic                  out_valid_q;
  logic [OutDataW-1:0]   out_data_q;
  logic                  out_last_q;
  logic [ColorW-1:0]     acc_q;
  logic [ColorW-1:0]     acc_d;

  logic                  out_free;
  logic                  advance;
  logic                  s_xfer;

  rank_info_t                           info;
  logic [PlaneSlots-1:0][FieldW-1:0]    plane_out;
  logic [ColorW-1:0]                    changes;
  logic [ColorW-1:0]                    changed_next;

  logic                  out_quiet;
  logic                  out_contig;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || out_free;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  mpcbc_rank #(
    .COLUMN_HEIGHT(COLUMN_HEIGHT)
  ) u_rank (
    .occupancy_i(s1_data_q[FieldW-1:0]),
    .info_o     (info)
  );

  for (genvar i = 0; i < PlaneSlots; i++) begin : g_plane
    if (i < NUM_COLORS) begin : g_used
      mpcbc_compress u_compress (
        .info_i   (info),
        .plane_i  (s1_data_q[FieldW*(i+1) +: FieldW]),
        .packed_o (plane_out[i]),
        .changed_o(changes[i])
      );
    end else begin : g_unused
      assign plane_out[i] = '0;
      assign changes[i]   = 1'b0;
    end
  end

  assign changed_next = acc_q | changes;
  // Clear the running mask after the last column of a pass.
  assign acc_d        = s1_last_q ? '0 : changed_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (s_axis_tready_o) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (advance) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      s1_data_q <= s_axis_tdata_i;
      s1_last_q <= s_axis_tlast_i;
    end
    if (advance) begin
      out_data_q <= {{OutPadW{1'b0}}, changed_next, plane_out, info.packed_occ};
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  assign out_quiet  = (out_data_q[FieldW*(PlaneSlots+1) +: ColorW] & ~UsedMask) == '0;
  assign out_contig = ((out_data_q[FieldW-1:0] + FieldW'(1)) & out_data_q[FieldW-1:0]) == '0;

  `MPCBC_ASSERT(a_acc_cleared, advance && s1_last_q |=> acc_q == '0, "accumulator not cleared")
  `MPCBC_ASSERT(a_unused_quiet, out_valid_q |-> out_quiet, "change bit set for unused color")
  `MPCBC_ASSERT(a_occ_contig, out_valid_q |-> out_contig, "packed occupancy not contiguous")
  `MPCBC_ASSERT(a_s1_hold, s1_valid_q && !out_free |=> s1_valid_q, "staged column dropped")

endmodule

`default_nettype wire

// ----- hw/rtl/mpcbc_rank.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpcbc_rank #(
  parameter int COLUMN_HEIGHT = 16
) (
  input  mpcbc_pkg::field_t     occupancy_i,
  output mpcbc_pkg::rank_info_t info_o
);
  import mpcbc_pkg::*;

  localparam int     EffHeight = (COLUMN_HEIGHT < FieldW) ? COLUMN_HEIGHT : FieldW;
  localparam field_t ColMask   = FieldW'((64'(1) << EffHeight) - 64'(1));

  field_t             occ;
  logic [CountW-1:0]  total;
  logic [FieldW:0]    occ_inc;

  // Cells above the column height count as empty.
  assign occ     = occupancy_i & ColMask;
  assign total   = CountW'($countones(occ));
  assign occ_inc = {1'b0, occ} + (FieldW+1)'(1);

  always_comb begin
    info_o.occ        = occ;
    info_o.packed_col = ((occ_inc[FieldW-1:0] & occ) == '0);
    info_o.packed_occ = FieldW'(((FieldW+1)'(1) << total) - (FieldW+1)'(1));
    for (int b = 0; b < FieldW; b++) begin
      info_o.rank[b] = RankW'($countones(occ & FieldW'((32'(1) << b) - 32'(1))));
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mpcbc_compress.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpcbc_compress (
  input  mpcbc_pkg::rank_info_t info_i,
  input  mpcbc_pkg::field_t     plane_i,
  output mpcbc_pkg::field_t     packed_o,
  output logic                  changed_o
);
  import mpcbc_pkg::*;

  field_t comp;

  // Each output cell picks the occupied input cell whose rank equals its index.
  always_comb begin
    comp = '0;
    for (int k = 0; k < FieldW; k++) begin
      for (int b = 0; b < FieldW; b++) begin
        comp[k] = comp[k] | (info_i.occ[b] & plane_i[b] & (info_i.rank[b] == RankW'(k)));
      end
    end
  end

  // Already packed column: pass the plane through untouched.
  assign packed_o  = info_i.packed_col ? plane_i : comp;
  assign changed_o = (packed_o != plane_i);

endmodule

`default_nettype wire
